// File: hdl/lsac_pkg.sv
package lsac_pkg;

  localparam int unsigned COLOR_BITS        = 8;
  localparam int unsigned OPACITY_FRAC_BITS = 8;

  localparam int unsigned OP_W      = OPACITY_FRAC_BITS + 1;
  localparam int unsigned ANUM_W    = 2 * OPACITY_FRAC_BITS + 1;
  localparam int unsigned NUM_W     = COLOR_BITS + 2 * OPACITY_FRAC_BITS + 1;
  localparam int unsigned BIT_IDX_W = (COLOR_BITS > 1) ? $clog2(COLOR_BITS) : 1;
  localparam int unsigned NUM_CH    = 3;
  localparam int unsigned CH_W      = $clog2(NUM_CH);

  localparam logic [OP_W-1:0] OP_ONE = OP_W'(1) << OPACITY_FRAC_BITS;

  typedef struct packed {
    logic [COLOR_BITS-1:0] pixel_blue;
    logic [COLOR_BITS-1:0] pixel_green;
    logic [COLOR_BITS-1:0] pixel_red;
    logic [COLOR_BITS-1:0] pixel_alpha;
    logic [OP_W-1:0]       layer_opacity;
    logic                  layer_visible;
    logic                  last_layer;
  } in_item_t;

  typedef struct packed {
    logic [COLOR_BITS-1:0] out_blue;
    logic [COLOR_BITS-1:0] out_green;
    logic [COLOR_BITS-1:0] out_red;
    logic [COLOR_BITS-1:0] out_alpha;
    logic                  no_visible_layer;
  } out_item_t;

endpackage

// File: hdl/layer_stack_alpha_compositor.sv
// Channel | Direction | Handshake                      | Payload
// in      | input     | in_valid_i / in_ready_o        | in_item_i  (lsac_pkg::in_item_t)
// out     | output    | out_valid_o / out_ready_i      | out_item_o (lsac_pkg::out_item_t)
//
// An invisible layer or the first visible layer of a pixel goes from S_IDLE
// straight to S_FINISH. A blended layer passes S_WEIGHT, then S_NUM and S_DIV per
// channel, on one shared compare-subtract unit doing a restoring divide per channel.
// rst_ni clears the sequencer, the pixel state and the output register.
// A last-layer item waits for a free output register; a held result does not
// stop the next item from being accepted.
module layer_stack_alpha_compositor (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lsac_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lsac_pkg::out_item_t out_item_o
);

  localparam int unsigned C  = lsac_pkg::COLOR_BITS;
  localparam int unsigned F  = lsac_pkg::OPACITY_FRAC_BITS;
  localparam int unsigned OW = lsac_pkg::OP_W;
  localparam int unsigned AW = lsac_pkg::ANUM_W;
  localparam int unsigned NW = lsac_pkg::NUM_W;
  localparam int unsigned BW = lsac_pkg::BIT_IDX_W;
  localparam int unsigned CW = lsac_pkg::CH_W;
  localparam int unsigned NC = lsac_pkg::NUM_CH;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WEIGHT,
    S_NUM,
    S_DIV,
    S_FINISH
  } state_e;

  state_e              state_q;
  logic [C-1:0]        comp_q [NC];
  logic [C-1:0]        layer_q [NC];
  logic [C-1:0]        alpha_q;
  logic [C-1:0]        layer_alpha_q;
  logic [OW-1:0]       acc_q;
  logic [OW-1:0]       op_q;
  logic                seen_q;
  logic                last_q;
  logic [AW-1:0]       weight_q;
  logic [AW-1:0]       anum_q;
  logic [NW-1:0]       rem_q;
  logic [C-1:0]        quo_q;
  logic [BW-1:0]       bit_q;
  logic [CW-1:0]       ch_q;
  logic                out_valid_q;
  lsac_pkg::out_item_t out_item_q;

  logic [OW-1:0] op_sat;
  logic [OW-1:0] inv_t;
  logic [AW-1:0] weight_d;
  logic [AW-1:0] anum_d;
  logic [NW-1:0] upper_term;
  logic [NW-1:0] lower_term;
  logic [NW-1:0] num_d;
  logic [NW-1:0] div_shift;
  logic          fits;
  logic [NW-1:0] rem_d;
  logic [C-1:0]  quo_d;
  logic          accept;
  logic          emit;

  assign accept = in_valid_i && (state_q == S_IDLE);
  assign emit   = (state_q == S_FINISH) && last_q && (!out_valid_q || out_ready_i);
  assign op_sat = (in_item_i.layer_opacity > lsac_pkg::OP_ONE) ? lsac_pkg::OP_ONE
                                                               : in_item_i.layer_opacity;

  assign inv_t      = lsac_pkg::OP_ONE - acc_q;
  assign weight_d   = AW'(inv_t) * AW'(op_q);
  assign anum_d     = AW'({acc_q, {F{1'b0}}}) + weight_d;
  assign upper_term = NW'(comp_q[ch_q]) * NW'(acc_q);
  assign lower_term = NW'(layer_q[ch_q]) * NW'(weight_q);
  assign num_d      = (upper_term << F) + lower_term;
  assign div_shift  = NW'(anum_q) << bit_q;
  assign fits       = rem_q >= div_shift;
  assign rem_d      = fits ? (rem_q - div_shift) : rem_q;
  assign quo_d      = quo_q | (C'(fits) << bit_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      for (int i = 0; i < NC; i++) begin
        comp_q[i]  <= '0;
        layer_q[i] <= '0;
      end
      alpha_q       <= '0;
      layer_alpha_q <= '0;
      acc_q         <= '0;
      op_q          <= '0;
      seen_q        <= 1'b0;
      last_q        <= 1'b0;
      weight_q      <= '0;
      anum_q        <= '0;
      rem_q         <= '0;
      quo_q         <= '0;
      ch_q          <= '0;
      bit_q         <= '0;
      out_valid_q   <= 1'b0;
      out_item_q    <= '0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            layer_q[0]    <= in_item_i.pixel_blue;
            layer_q[1]    <= in_item_i.pixel_green;
            layer_q[2]    <= in_item_i.pixel_red;
            layer_alpha_q <= in_item_i.pixel_alpha;
            op_q          <= op_sat;
            last_q        <= in_item_i.last_layer;
            if (in_item_i.layer_visible && !seen_q) begin
              comp_q[0] <= in_item_i.pixel_blue;
              comp_q[1] <= in_item_i.pixel_green;
              comp_q[2] <= in_item_i.pixel_red;
              alpha_q   <= in_item_i.pixel_alpha;
              acc_q     <= op_sat;
              seen_q    <= 1'b1;
              state_q   <= S_FINISH;
            end else if (in_item_i.layer_visible) begin
              state_q <= S_WEIGHT;
            end else begin
              state_q <= S_FINISH;
            end
          end
        end
        S_WEIGHT: begin
          weight_q <= weight_d;
          anum_q   <= anum_d;
          ch_q     <= '0;
          state_q  <= S_NUM;
        end
        S_NUM: begin
          rem_q   <= num_d;
          quo_q   <= '0;
          bit_q   <= BW'(C - 1);
          state_q <= S_DIV;
        end
        S_DIV: begin
          rem_q <= rem_d;
          quo_q <= quo_d;
          if (bit_q == '0) begin
            comp_q[ch_q] <= (anum_q == '0) ? '0 : quo_d;
            if (ch_q == CW'(NC - 1)) begin
              acc_q   <= OW'(anum_q >> F);
              alpha_q <= layer_alpha_q;
              state_q <= S_FINISH;
            end else begin
              ch_q    <= ch_q + 1'b1;
              state_q <= S_NUM;
            end
          end else begin
            bit_q <= bit_q - 1'b1;
          end
        end
        S_FINISH: begin
          if (!last_q) begin
            state_q <= S_IDLE;
          end else if (emit) begin
            if (seen_q) begin
              out_item_q <= '{out_blue: comp_q[0], out_green: comp_q[1],
                              out_red: comp_q[2], out_alpha: alpha_q,
                              no_visible_layer: 1'b0};
            end else begin
              out_item_q <= '{out_blue: '0, out_green: '0, out_red: '0,
                              out_alpha: '0, no_visible_layer: 1'b1};
            end
            for (int i = 0; i < NC; i++) begin
              comp_q[i] <= '0;
            end
            alpha_q <= '0;
            acc_q   <= '0;
            seen_q  <= 1'b0;
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// File: hdl/lsac_checker.sv
module lsac_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input lsac_pkg::out_item_t out_item_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_item_o))
    else $error("stalled result item changed");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.no_visible_layer |->
      out_item_o.out_blue == '0 && out_item_o.out_green == '0 &&
      out_item_o.out_red == '0 && out_item_o.out_alpha == '0)
    else $error("empty pixel carries colour");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready straight after accepting an item");

endmodule

bind layer_stack_alpha_compositor lsac_checker u_lsac_checker (.*);
